FILE: rtl/core/extended_gcd_bezout_defines.svh
// Assertion macros for the checker file of this block.
`ifndef EXTENDED_GCD_BEZOUT_DEFINES_SVH
`define EXTENDED_GCD_BEZOUT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EGCD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define EGCD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/egcd_pkg.sv
package egcd_pkg;

  // Operand and gcd width.
  localparam int unsigned OpW = 31;
  // Width of the coefficient result ports.
  localparam int unsigned CoeffPortW = 32;
  // Default width of the internal coefficient arithmetic.
  localparam int unsigned DataWidthDef = 32;

  // One quotient bit per division step.
  localparam int unsigned StepCntW = $clog2(OpW);
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(OpW - 1);

  typedef logic [OpW-1:0] operand_t;
  typedef logic [StepCntW-1:0] step_cnt_t;

endpackage

FILE: rtl/core/extended_gcd_bezout.sv
// Extended Euclid engine: a request on start (taken while busy is low)
// carries operands a and b; one result comes back on done_o with the gcd
// and the Bezout coefficients x, y so that x*a + y*b = gcd, in two's
// complement. When b divides a the result is gcd b, x 0, y 1. A zero b
// returns zero_divisor_error_o set and all other fields zero, strobed in
// the cycle right after the request. done_o is high for exactly one cycle
// and the results hold only until the next one: the receiver cannot
// stall, so sample them on that cycle. Each Euclid step runs one
// bit-serial restoring division (state StDiv) on a single shared step
// unit, followed by one coefficient update (state StUpd), so a request
// with k divisions runs k such steps (k is at most 45 for 31-bit
// operands). busy stays high until the result strobe; a new request
// can be taken in the strobe cycle.
// DATA_WIDTH sets the internal coefficient width; results are that
// width's two's complement bits, truncated or zero-padded to 32 bits.
module extended_gcd_bezout #(
  parameter int unsigned DATA_WIDTH = egcd_pkg::DataWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  egcd_pkg::operand_t                first_value_i,
  input  egcd_pkg::operand_t                second_value_i,
  output logic                              done_o,
  output egcd_pkg::operand_t                divisor_result_o,
  output logic [egcd_pkg::CoeffPortW-1:0]   coeff_first_o,
  output logic [egcd_pkg::CoeffPortW-1:0]   coeff_second_o,
  output logic                              zero_divisor_error_o
);

  localparam int unsigned CoeffW = DATA_WIDTH;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StDiv  = 3'b010,
    StUpd  = 3'b100
  } state_e;

  state_e state_q, state_d;
  egcd_pkg::step_cnt_t cnt_q, cnt_d;

  // Division operands: shifting dividend, divisor, partial remainder.
  egcd_pkg::operand_t dvd_q, dvd_d;
  egcd_pkg::operand_t dvs_q, dvs_d;
  egcd_pkg::operand_t rem_q, rem_d;

  // Coefficient pairs and the running products q*xc, q*yc.
  logic [CoeffW-1:0] xp_q, xp_d, xc_q, xc_d;
  logic [CoeffW-1:0] yp_q, yp_d, yc_q, yc_d;
  logic [CoeffW-1:0] acc_x_q, acc_x_d, acc_y_q, acc_y_d;

  // Result registers.
  logic                done_q, done_d;
  egcd_pkg::operand_t  res_gcd_q, res_gcd_d;
  logic [CoeffW-1:0]   res_x_q, res_x_d, res_y_q, res_y_d;
  logic                res_err_q, res_err_d;

  // Shared step unit outputs.
  egcd_pkg::operand_t step_rem;
  logic               step_qbit;
  logic [CoeffW-1:0]  step_acc_x, step_acc_y;

  logic accept;

  egcd_step #(
    .COEFF_W (CoeffW)
  ) u_step (
    .rem_i     (rem_q),
    .dvd_bit_i (dvd_q[egcd_pkg::OpW-1]),
    .dvs_i     (dvs_q),
    .acc_x_i   (acc_x_q),
    .acc_y_i   (acc_y_q),
    .coeff_x_i (xc_q),
    .coeff_y_i (yc_q),
    .rem_o     (step_rem),
    .qbit_o    (step_qbit),
    .acc_x_o   (step_acc_x),
    .acc_y_o   (step_acc_y)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    rem_d     = rem_q;
    xp_d      = xp_q;
    xc_d      = xc_q;
    yp_d      = yp_q;
    yc_d      = yc_q;
    acc_x_d   = acc_x_q;
    acc_y_d   = acc_y_q;
    done_d    = 1'b0;
    res_gcd_d = res_gcd_q;
    res_x_d   = res_x_q;
    res_y_d   = res_y_q;
    res_err_d = res_err_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (second_value_i == '0) begin
            // Zero divisor: answer at once, stay idle.
            done_d    = 1'b1;
            res_gcd_d = '0;
            res_x_d   = '0;
            res_y_d   = '0;
            res_err_d = 1'b1;
          end else begin
            // Load a / b and the starting pairs (1,0), (0,1).
            dvd_d   = first_value_i;
            dvs_d   = second_value_i;
            rem_d   = '0;
            acc_x_d = '0;
            acc_y_d = '0;
            xp_d    = CoeffW'(1);
            xc_d    = '0;
            yp_d    = '0;
            yc_d    = CoeffW'(1);
            cnt_d   = '0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        // Advance one quotient bit and both products.
        dvd_d   = {dvd_q[egcd_pkg::OpW-2:0], 1'b0};
        rem_d   = step_rem;
        acc_x_d = step_acc_x;
        acc_y_d = step_acc_y;
        if (cnt_q == egcd_pkg::LastStep) begin
          state_d = StUpd;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StUpd: begin
        if (rem_q == '0) begin
          // Remainder gone: the divisor is the gcd.
          done_d    = 1'b1;
          res_gcd_d = dvs_q;
          res_x_d   = xc_q;
          res_y_d   = yc_q;
          res_err_d = 1'b0;
          state_d   = StIdle;
        end else begin
          // Shift the pairs and the operands for the next division.
          xp_d    = xc_q;
          xc_d    = xp_q - acc_x_q;
          yp_d    = yc_q;
          yc_d    = yp_q - acc_y_q;
          dvd_d   = dvs_q;
          dvs_d   = rem_q;
          rem_d   = '0;
          acc_x_d = '0;
          acc_y_d = '0;
          cnt_d   = '0;
          state_d = StDiv;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    rem_q     <= rem_d;
    xp_q      <= xp_d;
    xc_q      <= xc_d;
    yp_q      <= yp_d;
    yc_q      <= yc_d;
    acc_x_q   <= acc_x_d;
    acc_y_q   <= acc_y_d;
    res_gcd_q <= res_gcd_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    res_err_q <= res_err_d;
  end

  // Fit the coefficient bits to the 32-bit ports.
  generate
    if (CoeffW >= egcd_pkg::CoeffPortW) begin : g_trunc
      assign coeff_first_o  = res_x_q[egcd_pkg::CoeffPortW-1:0];
      assign coeff_second_o = res_y_q[egcd_pkg::CoeffPortW-1:0];
    end else begin : g_pad
      assign coeff_first_o  = {{(egcd_pkg::CoeffPortW-CoeffW){1'b0}}, res_x_q};
      assign coeff_second_o = {{(egcd_pkg::CoeffPortW-CoeffW){1'b0}}, res_y_q};
    end
  endgenerate

  assign done_o               = done_q;
  assign divisor_result_o     = res_gcd_q;
  assign zero_divisor_error_o = res_err_q;

endmodule

FILE: rtl/core/egcd_step.sv
// One restoring-division step plus the matching shift-and-add of the
// quotient bit into both coefficient products.
module egcd_step #(
  parameter int unsigned COEFF_W = egcd_pkg::DataWidthDef
) (
  input  egcd_pkg::operand_t rem_i,
  input  logic               dvd_bit_i,
  input  egcd_pkg::operand_t dvs_i,
  input  logic [COEFF_W-1:0] acc_x_i,
  input  logic [COEFF_W-1:0] acc_y_i,
  input  logic [COEFF_W-1:0] coeff_x_i,
  input  logic [COEFF_W-1:0] coeff_y_i,
  output egcd_pkg::operand_t rem_o,
  output logic               qbit_o,
  output logic [COEFF_W-1:0] acc_x_o,
  output logic [COEFF_W-1:0] acc_y_o
);

  logic [egcd_pkg::OpW:0] trial;
  logic [egcd_pkg::OpW:0] dvs_ext;
  logic [egcd_pkg::OpW:0] diff;

  assign trial   = {rem_i, dvd_bit_i};
  assign dvs_ext = {1'b0, dvs_i};
  assign diff    = trial - dvs_ext;
  assign qbit_o  = (trial >= dvs_ext);
  // Restore when the trial remainder falls below the divisor.
  assign rem_o   = qbit_o ? diff[egcd_pkg::OpW-1:0] : trial[egcd_pkg::OpW-1:0];

  // Horner accumulation: acc = 2*acc + qbit*coeff, MSB first.
  assign acc_x_o = {acc_x_i[COEFF_W-2:0], 1'b0} + (qbit_o ? coeff_x_i : '0);
  assign acc_y_o = {acc_y_i[COEFF_W-2:0], 1'b0} + (qbit_o ? coeff_y_i : '0);

endmodule

FILE: rtl/core/egcd_checker.sv
`include "extended_gcd_bezout_defines.svh"

module egcd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input egcd_pkg::operand_t              first_value_i,
  input egcd_pkg::operand_t              second_value_i,
  input logic                            done_o,
  input egcd_pkg::operand_t              divisor_result_o,
  input logic [egcd_pkg::CoeffPortW-1:0] coeff_first_o,
  input logic [egcd_pkg::CoeffPortW-1:0] coeff_second_o,
  input logic                            zero_divisor_error_o
);

  `EGCD_ASSERT_NXT(a_zero_div_next, start && !busy && (second_value_i == '0), done_o && zero_divisor_error_o && !busy, "zero divisor request not answered next cycle")

  `EGCD_ASSERT_NXT(a_work_busy, start && !busy && (second_value_i != '0), busy && !done_o, "nonzero divisor request did not hold busy")

  `EGCD_ASSERT_IMP(a_err_zero, done_o && zero_divisor_error_o, (divisor_result_o == '0) && (coeff_first_o == '0) && (coeff_second_o == '0), "error result carries nonzero fields")

  `EGCD_ASSERT_IMP(a_gcd_nonzero, done_o && !zero_divisor_error_o, divisor_result_o != '0, "gcd of zero without error")

  `EGCD_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while still busy")

endmodule

bind extended_gcd_bezout egcd_checker u_egcd_checker (.*);

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef egcd_pkg::operand_t operand_t;
  localparam int unsigned CoeffPortW = egcd_pkg::CoeffPortW;

  localparam int unsigned RandomRequests = 400;
  // The limit allows for the slowest requests plus sender gaps and is
  // several times the slowest clean run.
  localparam longint unsigned TimeoutNs = 64'd40_000_000;
  localparam operand_t OperandMax = '1;
  // Consecutive Fibonacci numbers give the longest division chains.
  localparam operand_t Fib44 = 31'd701408733;
  localparam operand_t Fib45 = 31'd1134903170;
  localparam operand_t Fib46 = 31'd1836311903;

  // One expected result, with the operands kept for the mismatch report.
  typedef struct packed {
    operand_t                gcd;
    logic [CoeffPortW-1:0]   x;
    logic [CoeffPortW-1:0]   y;
    logic                    err;
    operand_t                op_a;
    operand_t                op_b;
  } bezout_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  operand_t              first_value_i = '0;
  operand_t              second_value_i = '0;
  logic                  done_o;
  operand_t              divisor_result_o;
  logic [CoeffPortW-1:0] coeff_first_o;
  logic [CoeffPortW-1:0] coeff_second_o;
  logic                  zero_divisor_error_o;

  bezout_t bezout_q[$];
  bezout_t head_res;
  int      mismatch_cnt = 0;
  int      result_cnt = 0;
  int      request_cnt = 0;
  int      zero_div_cnt = 0;
  int      exact_div_cnt = 0;
  int      longest_chain = 0;
  // Sender pacing: bursts of back-to-back requests separated by idle gaps.
  bit      gaps_on = 1'b1;
  int      burst_left = 1;

  extended_gcd_bezout u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .first_value_i        (first_value_i),
    .second_value_i       (second_value_i),
    .done_o               (done_o),
    .divisor_result_o     (divisor_result_o),
    .coeff_first_o        (coeff_first_o),
    .coeff_second_o       (coeff_second_o),
    .zero_divisor_error_o (zero_divisor_error_o)
  );

  always #5 clk_i = ~clk_i;

  // Run the extended Euclid recurrence on the operands and return gcd and
  // Bezout pair; n_div counts the divisions for the run summary.
  function automatic bezout_t predict_bezout(input operand_t a_in, input operand_t b_in,
                                             output int n_div);
    bezout_t res;
    longint  num, den, quo, rem, xp, xc, yp, yc, xn, yn;
    res = '0;
    res.op_a = a_in;
    res.op_b = b_in;
    n_div = 0;
    // Zero divisor: flag it and leave every other field zero.
    if (b_in == '0) begin
      res.err = 1'b1;
      return res;
    end
    num = longint'(a_in);
    den = longint'(b_in);
    xp = 1;
    xc = 0;
    yp = 0;
    yc = 1;
    quo = num / den;
    rem = num % den;
    n_div = 1;
    while (rem != 0) begin
      xn = xp - quo * xc;
      yn = yp - quo * yc;
      num = den;
      den = rem;
      quo = num / den;
      rem = num % den;
      xp = xc;
      xc = xn;
      yp = yc;
      yc = yn;
      n_div++;
    end
    res.gcd = operand_t'(den);
    // Coefficients are two's complement, cut to the port width.
    res.x = xc[CoeffPortW-1:0];
    res.y = yc[CoeffPortW-1:0];
    return res;
  endfunction

  // Present one request, hold it until taken, then log what it should return.
  // Leave start high when the burst goes on so no lower/raise lands in one step.
  task automatic send_request(input operand_t a, input operand_t b);
    bezout_t exp_res;
    int      n_div;
    int      gap;
    first_value_i <= a;
    second_value_i <= b;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    exp_res = predict_bezout(a, b, n_div);
    bezout_q = {bezout_q, exp_res};
    request_cnt++;
    if (exp_res.err) zero_div_cnt++;
    else if (n_div == 1) exact_div_cnt++;
    if (n_div > longest_chain) longest_chain = n_div;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 6);
      gap = 0;
      if (gaps_on) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: gap = $urandom_range(1, 40);
          7, 8:                gap = $urandom_range(41, 200);
          default:             gap = 0;
        endcase
      end
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Zero divisor, with zero and nonzero dividends.
  task automatic test_zero_divisor();
    send_request('0, '0);
    send_request(OperandMax, '0);
    send_request(31'd12345, '0);
  endtask

  // b divides a, a zero dividend included: expect gcd b, x 0, y 1.
  task automatic test_exact_division();
    send_request('0, 31'd5);
    send_request('0, OperandMax);
    send_request(OperandMax, 31'd1);
    send_request(OperandMax, OperandMax);
    send_request(31'd100, 31'd25);
    send_request(31'd7, 31'd7);
    send_request(31'd1, 31'd1);
  endtask

  // Field extremes, alternating bit patterns and a smaller first operand.
  task automatic test_operand_extremes();
    send_request(31'd1, OperandMax);
    send_request(OperandMax, OperandMax - 31'd1);
    send_request(OperandMax, 31'd2);
    send_request(31'h40000000, 31'h3FFFFFFF);
    send_request(31'h55555555, 31'h2AAAAAAA);
    send_request(31'h2AAAAAAA, 31'h55555555);
    send_request(31'd3, 31'd7);
    send_request(31'd240, 31'd46);
  endtask

  // Long division chains from consecutive Fibonacci operands.
  task automatic test_longest_chain();
    send_request(Fib46, Fib45);
    send_request(Fib45, Fib44);
  endtask

  // Random mix shaped to hit long chains, shared factors, exact division and
  // zero divisors as well as plain full-width noise and small operands.
  task automatic test_random_pairs(input int unsigned n_req);
    operand_t          fib[0:46];
    operand_t          a, b, tmp;
    longint unsigned   g, m, k;
    int                idx;
    fib[0] = '0;
    fib[1] = 31'd1;
    for (idx = 2; idx <= 46; idx++) fib[idx] = fib[idx-1] + fib[idx-2];
    for (int unsigned i = 0; i < n_req; i++) begin
      // Run the first quarter back to back, then pace with gaps again.
      gaps_on = (i >= n_req / 4);
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: begin
          a = operand_t'($urandom());
          b = operand_t'($urandom());
        end
        5, 6: begin
          // Random bit lengths spread the chain length.
          a = operand_t'($urandom() >> $urandom_range(0, 31));
          b = operand_t'($urandom() >> $urandom_range(0, 31));
        end
        7, 8: begin
          g = $urandom_range(1, 1000);
          m = $urandom_range(0, 2_000_000);
          k = $urandom_range(1, 2_000_000);
          a = operand_t'(g * m);
          b = operand_t'(g * k);
        end
        9: begin
          b = operand_t'($urandom_range(1, 65535));
          a = operand_t'(longint'(b) * $urandom_range(0, 32767));
        end
        10, 11: begin
          // Scaled Fibonacci pair: Fibonacci-length chain with gcd k.
          idx = $urandom_range(2, 46);
          k = $urandom_range(1, int'(longint'(OperandMax) / longint'(fib[idx])));
          a = operand_t'(longint'(fib[idx]) * k);
          b = operand_t'(longint'(fib[idx-1]) * k);
          if ($urandom_range(0, 1)) begin
            tmp = a;
            a = b;
            b = tmp;
          end
        end
        12: begin
          a = operand_t'($urandom());
          b = '0;
        end
        13: begin
          b = operand_t'($urandom());
          case ($urandom_range(0, 2))
            0:       a = '0;
            1:       a = b;
            default: begin
              a = b;
              b = 31'd1;
            end
          endcase
        end
        default: begin
          a = operand_t'($urandom_range(0, 255));
          b = operand_t'($urandom_range(0, 255));
        end
      endcase
      send_request(a, b);
    end
  endtask

  // Results cannot be held off, so take every strobe and compare it
  // against the oldest request still waiting.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_cnt++;
      if (bezout_q.size() == 0) begin
        $display("%0t: result with no request waiting: gcd %0d x %0d y %0d err %0b",
                 $time, divisor_result_o, $signed(coeff_first_o),
                 $signed(coeff_second_o), zero_divisor_error_o);
        mismatch_cnt++;
      end else begin
        head_res = bezout_q.pop_front();
        if (divisor_result_o !== head_res.gcd) begin
          $display("%0t: a=%0d b=%0d gcd expected %0d actual %0d", $time,
                   head_res.op_a, head_res.op_b, head_res.gcd, divisor_result_o);
          mismatch_cnt++;
        end
        if (coeff_first_o !== head_res.x) begin
          $display("%0t: a=%0d b=%0d x expected %0d actual %0d", $time,
                   head_res.op_a, head_res.op_b, $signed(head_res.x),
                   $signed(coeff_first_o));
          mismatch_cnt++;
        end
        if (coeff_second_o !== head_res.y) begin
          $display("%0t: a=%0d b=%0d y expected %0d actual %0d", $time,
                   head_res.op_a, head_res.op_b, $signed(head_res.y),
                   $signed(coeff_second_o));
          mismatch_cnt++;
        end
        if (zero_divisor_error_o !== head_res.err) begin
          $display("%0t: a=%0d b=%0d error flag expected %0b actual %0b", $time,
                   head_res.op_a, head_res.op_b, head_res.err, zero_divisor_error_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    // Hold reset low, then release it on a clock edge.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_divisor();
    test_exact_division();
    test_operand_extremes();
    test_longest_chain();
    test_random_pairs(RandomRequests);

    // Drop start, drain the pending results, then watch a little longer
    // for any stray strobe.
    start <= 1'b0;
    while (bezout_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (bezout_q.size() != 0) begin
      $display("%0t: %0d requests never answered", $time, bezout_q.size());
      mismatch_cnt++;
    end
    $display("Covered %0d requests, %0d results: %0d zero divisors, %0d exact divisions",
             request_cnt, result_cnt, zero_div_cnt, exact_div_cnt);
    $display("Longest division chain %0d, %0d mismatches", longest_chain, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin
    #(TimeoutNs);
    $display("%0t: timeout with %0d requests still waiting", $time, bezout_q.size());
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/egcd_pkg.sv
rtl/core/egcd_step.sv
rtl/core/extended_gcd_bezout.sv
rtl/core/egcd_checker.sv
sim/testbench.sv
